// ===== design/scbe_pkg.sv =====
// Package with sizes, types and codes shared by the slot cache modules.
`default_nettype none
package scbe_pkg;
  localparam int unsigned Slots = 64;
  localparam int unsigned EvictCount = Slots / 4;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned EvW = $clog2(EvictCount + 1);
  localparam int unsigned KeyW = 32;

  typedef enum logic [0:0] {
    ActLookup = 1'b0,
    ActFree   = 1'b1
  } action_e;

  typedef struct packed {
    logic          action;
    logic [KeyW-1:0] image_id;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanWait,
    StDecide,
    StEvScan,
    StEvWait,
    StEvTake,
    StPop,
    StPopWait,
    StBind,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic ev_start;
    logic ev_step;
    logic ev_take;
    logic do_free;
    logic pop_read;
    logic bind_slot;
    logic miss_noslot;
    logic set_hit;
    logic out_valid_set;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic scan_last;
    logic hit;
    logic stack_empty;
    logic ev_found;
    logic ev_last;
    logic ev_done;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/scbe_if.sv =====
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface scbe_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/scbe_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module scbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/scbe_ctrl.sv =====
// Controller state machine sequencing search, eviction and allocation.
`default_nettype none
module scbe_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire scbe_pkg::sts_t sts_i,
  output scbe_pkg::cmd_t      cmd_o
);
  import scbe_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (in_valid_i) state_d = StScan;
      StScan:     state_d = StScanWait;
      StScanWait: if (sts_i.scan_last) state_d = StDecide;
      StDecide: begin
        if (sts_i.hit || sts_i.action == ActFree) state_d = StOut;
        else if (sts_i.stack_empty) state_d = StEvScan;
        else state_d = StPop;
      end
      StEvScan:   state_d = StEvWait;
      StEvWait:   if (sts_i.scan_last) state_d = StEvTake;
      StEvTake: begin
        if (!sts_i.ev_found || sts_i.ev_last) state_d = StPop;
        else state_d = StEvScan;
      end
      StPop: begin
        if (sts_i.stack_empty) state_d = StOut;
        else state_d = StPopWait;
      end
      StPopWait:  state_d = StBind;
      StBind:     state_d = StOut;
      StOut:      if (!sts_i.out_busy) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      StScan:     cmd_o.scan_start = 1'b1;
      StScanWait: cmd_o.scan_step = 1'b1;
      StDecide: begin
        cmd_o.set_hit = 1'b1;
        cmd_o.do_free = sts_i.action == ActFree && sts_i.hit;
      end
      StEvScan:   cmd_o.ev_start = 1'b1;
      StEvWait:   cmd_o.ev_step = 1'b1;
      StEvTake:   cmd_o.ev_take = 1'b1;
      StPop: begin
        cmd_o.pop_read = !sts_i.stack_empty;
        cmd_o.miss_noslot = sts_i.stack_empty;
      end
      StBind:     cmd_o.bind_slot = 1'b1;
      StOut:      cmd_o.out_valid_set = !sts_i.out_busy;
      default:    cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/scbe_dp.sv =====
// Datapath: key memory, valid bits, free stack, scan unit and output register.
`default_nettype none
module scbe_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire scbe_pkg::req_t              req_i,
  input  wire scbe_pkg::cmd_t              cmd_i,
  output scbe_pkg::sts_t                   sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output scbe_pkg::rsp_t                   out_data_o
);
  import scbe_pkg::*;

  req_t             req_q;
  logic [Slots-1:0] valid_q;
  logic [CntW-1:0]  cnt_q;
  logic [SlotW-1:0] idx_q;       // scan address
  logic             rd_pend_q;   // read of entry zero not yet on rdata
  logic [SlotW-1:0] ridx_q;      // index of data now on rdata
  logic             scan_last_q;
  logic             hit_q;
  logic [SlotW-1:0] hit_idx_q;
  logic             best_ok_q;
  logic [KeyW-1:0]  best_ord_q;
  logic [SlotW-1:0] best_idx_q;
  logic [EvW-1:0]   ev_n_q;
  logic             out_valid_q;
  rsp_t             out_q;
  rsp_t             res_q;
  logic             pop_pend_q;
  logic [SlotW-1:0] pop_slot_q;

  logic [KeyW-1:0]  key_rdata;
  logic [SlotW-1:0] stk_rdata;
  logic             stk_we;
  logic [SlotW-1:0] stk_waddr, stk_wdata, stk_raddr;
  logic             key_we;
  logic [SlotW-1:0] pop_slot;
  logic [KeyW-1:0]  ord;
  logic             scanning;

  assign pop_slot = stk_rdata;

  // The stack below the fill count has never been pushed after reset for
  // entries that still hold their reset content: those read as the reset value.
  logic [Slots-1:0] stk_init_q;
  logic [SlotW-1:0] pop_addr_q;
  logic [SlotW-1:0] pop_val;
  assign pop_val = stk_init_q[pop_addr_q] ? pop_slot
                 : SlotW'(Slots - 1 - int'(pop_addr_q));

  scbe_ram #(.Width(KeyW), .Depth(Slots)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(pop_slot_q), .wdata_i(req_q.image_id),
    .raddr_i(idx_q), .rdata_o(key_rdata)
  );
  scbe_ram #(.Width(SlotW), .Depth(Slots)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign key_we = cmd_i.bind_slot;
  assign stk_waddr = cnt_q[SlotW-1:0];
  assign stk_we = (cmd_i.do_free || (cmd_i.ev_take && best_ok_q)) && cnt_q < CntW'(Slots);
  assign stk_wdata = cmd_i.do_free ? hit_idx_q : best_idx_q;
  assign stk_raddr = SlotW'(cnt_q - CntW'(1));
  assign ord = key_rdata ^ {1'b1, {(KeyW-1){1'b0}}};
  assign scanning = cmd_i.scan_step || cmd_i.ev_step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stk_init_q <= '0;
      cnt_q <= CntW'(Slots);
      idx_q <= '0;
      rd_pend_q <= 1'b0;
      ridx_q <= '0;
      scan_last_q <= 1'b0;
      hit_q <= 1'b0;
      hit_idx_q <= '0;
      best_ok_q <= 1'b0;
      best_ord_q <= '0;
      best_idx_q <= '0;
      ev_n_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      res_q <= '0;
      pop_addr_q <= '0;
      pop_pend_q <= 1'b0;
      pop_slot_q <= '0;
    end else begin
      if (cmd_i.scan_start || cmd_i.ev_start) begin
        idx_q <= '0;
        rd_pend_q <= 1'b1;
        scan_last_q <= 1'b0;
        ridx_q <= '0;
        if (cmd_i.scan_start) hit_q <= 1'b0;
        if (cmd_i.ev_start) best_ok_q <= 1'b0;
      end else if (scanning) begin
        idx_q <= idx_q + SlotW'(1);
        if (rd_pend_q) begin
          // The read of entry zero is still in flight this cycle.
          rd_pend_q <= 1'b0;
        end else begin
          // One key per cycle: compare data for ridx, advance address.
          if (valid_q[ridx_q]) begin
            if (cmd_i.scan_step && !hit_q && key_rdata == req_q.image_id) begin
              hit_q <= 1'b1;
              hit_idx_q <= ridx_q;
            end
            if (cmd_i.ev_step && (!best_ok_q || ord < best_ord_q)) begin
              best_ok_q <= 1'b1;
              best_ord_q <= ord;
              best_idx_q <= ridx_q;
            end
          end
          scan_last_q <= (ridx_q == SlotW'(Slots - 2));
          ridx_q <= ridx_q + SlotW'(1);
        end
      end
      if (cmd_i.load_req) ev_n_q <= '0;
      if (cmd_i.set_hit) begin
        res_q.found <= hit_q;
        res_q.slot <= hit_q ? hit_idx_q : '0;
      end
      if (cmd_i.do_free) begin
        valid_q[hit_idx_q] <= 1'b0;
        if (cnt_q < CntW'(Slots)) begin
          cnt_q <= cnt_q + CntW'(1);
          stk_init_q[stk_waddr] <= 1'b1;
        end
      end
      if (cmd_i.ev_take && best_ok_q) begin
        valid_q[best_idx_q] <= 1'b0;
        ev_n_q <= ev_n_q + EvW'(1);
        if (cnt_q < CntW'(Slots)) begin
          cnt_q <= cnt_q + CntW'(1);
          stk_init_q[stk_waddr] <= 1'b1;
        end
      end
      if (cmd_i.pop_read) begin
        cnt_q <= cnt_q - CntW'(1);
        pop_addr_q <= stk_raddr;
      end
      // The popped entry is on the stack read port in the cycle after the pop.
      pop_pend_q <= cmd_i.pop_read;
      if (pop_pend_q) pop_slot_q <= pop_val;
      if (cmd_i.miss_noslot) res_q <= '0;
      if (cmd_i.bind_slot) begin
        valid_q[pop_slot_q] <= 1'b1;
        res_q.found <= 1'b0;
        res_q.slot <= pop_slot_q;
      end
      if (cmd_i.out_valid_set) begin
        out_valid_q <= 1'b1;
        out_q <= res_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.action = req_q.action;
  assign sts_o.scan_last = scan_last_q;
  assign sts_o.hit = hit_q;
  assign sts_o.stack_empty = cnt_q == '0;
  assign sts_o.ev_found = best_ok_q;
  assign sts_o.ev_last = ev_n_q == EvW'(EvictCount - 1);
  assign sts_o.ev_done = ev_n_q == EvW'(EvictCount);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

// ===== design/slot_cache_with_batch_eviction_unit.sv =====
// Slot cache top level: maps signed image keys to cache slots.
// Requests arrive on in_i (action, image_id); one response per request
// leaves on out_o (found, slot). The block takes one request at a time.
// A request walks the key memory one slot per cycle, so a lookup hit or
// a free takes one full key-memory scan. A miss with free slots adds
// the stack pop and bind. A miss with an empty stack first evicts up to
// Slots/4 keys, each needing one full key-memory scan, then pops. The
// single read port of the key memory sets the pace of every scan.
// Reset clears all valid bits and fills the free stack with slot 0 on top;
// no clearing pass is needed. The response sits in an output register;
// while the receiver stalls the controller holds the new response until
// the register can take it, and the next request waits until then.
`default_nettype none
module slot_cache_with_batch_eviction_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  scbe_if.sink     in_i,
  scbe_if.source   out_o
);
  import scbe_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  req_t req;

  assign req = in_i.data;

  scbe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .sts_i(sts), .cmd_o(cmd)
  );
  scbe_dp u_dp (
    .clk_i, .rst_ni, .req_i(req), .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready), .out_data_o(rsp)
  );
  assign out_o.data = rsp;
endmodule
`default_nettype wire

// ===== design/scbe_checker.sv =====
// Port-level checker for the slot cache, bound to the top level.
`default_nettype none
module scbe_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_found,
  input wire logic [5:0] out_slot
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second request taken");
  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid || $past(out_valid))
    else $error("response too early");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_found))
    else $error("stalled response changed");
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown({out_found, out_slot}))
    else $error("response holds unknown bits");
endmodule

bind slot_cache_with_batch_eviction_unit scbe_checker u_scbe_checker (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_found(out_o.data.found), .out_slot(out_o.data.slot)
);
`default_nettype wire
